// ===== hw/rtl/rc_channel_frame_parser_defines.svh =====
// Assertion macros used by the rcfp_checker module.
// Each macro samples on clk and is muted while rst_n is low.
`ifndef RC_CHANNEL_FRAME_PARSER_DEFINES_SVH
`define RC_CHANNEL_FRAME_PARSER_DEFINES_SVH

// Whenever ante holds on an edge, cons must hold on that same edge.
`define RCFP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rcfp check failed");

// Whenever ante holds on an edge, cons must hold on the next edge.
`define RCFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rcfp check failed");

// The expression must never be true on any edge.
`define RCFP_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("rcfp check failed");

`endif

// ===== hw/rtl/rcfp_pkg.sv =====
package rcfp_pkg;

  localparam int MAX_PACKET_DEF   = 64;
  localparam int NUM_CHANNELS_DEF = 16;

  localparam int PAYLOAD_BYTES = 22;
  localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
  localparam int CHAN_BITS     = 11;
  localparam int FLOOR_LENGTH  = 24;
  localparam int CMP_W         = 10;
  localparam logic [7:0] CRC_POLY = 8'hD5;

  localparam logic [7:0] FRAME_TYPE_RST = 8'h16;
  localparam logic [5:0] MIN_LENGTH_RST = 6'd24;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TYPE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT_PKT = 3'd1,
    ST_SHORT_LEN = 3'd2,
    ST_OVERRUN   = 3'd3,
    ST_BAD_TYPE  = 3'd4,
    ST_BAD_CRC   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CS_RECV,
    CS_CHECK,
    CS_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_end;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        last;
  } out_t;

  typedef struct packed {
    logic take_byte;
    logic run_check;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
  } dp_stat_t;

  function automatic logic [7:0] crc8_upd(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/rcfp_ctrl.sv =====
module rcfp_ctrl
  import rcfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_end,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_RECV;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      CS_RECV: begin
        if (in_valid && in_end) state_nxt = CS_CHECK;
      end
      CS_CHECK: begin
        state_nxt = CS_EMIT;
      end
      CS_EMIT: begin
        if (out_ready && stat.last) state_nxt = CS_RECV;
      end
      default: begin
        state_nxt = CS_RECV;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd           = '0;
    case (state_r)
      CS_RECV: begin
        in_ready      = 1'b1;
        cmd.take_byte = in_valid;
      end
      CS_CHECK: begin
        cmd.run_check = 1'b1;
      end
      CS_EMIT: begin
        out_valid   = 1'b1;
        cmd.advance = out_ready && !stat.last;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rcfp_dp.sv =====
module rcfp_dp
  import rcfp_pkg::*;
#(
  parameter int MAX_PACKET   = MAX_PACKET_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_t                   in_data,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat
);

  localparam int CNT_W = $clog2(MAX_PACKET + 1);

  logic [CNT_W-1:0]     byte_count_r, byte_count_nxt;
  logic [7:0]           length_r, length_nxt;
  logic [7:0]           type_r, type_nxt;
  logic [7:0]           crc_r, crc_nxt;
  logic [7:0]           rx_crc_r, rx_crc_nxt;
  logic [PAYLOAD_W-1:0] payload_r, payload_nxt;
  logic [3:0]           ch_idx_r, ch_idx_nxt;
  status_t              status_r, status_nxt;
  logic [7:0]           frame_type_r;
  logic [5:0]           min_length_r;

  logic [CMP_W-1:0] pos;
  logic [CMP_W-1:0] len_w;
  logic [CMP_W-1:0] cnt_w;
  logic [CMP_W-1:0] minlen_w;
  logic             is_ok;

  assign pos      = CMP_W'(byte_count_r);
  assign len_w    = CMP_W'(length_r);
  assign cnt_w    = CMP_W'(byte_count_r);
  assign minlen_w = (min_length_r < 6'(FLOOR_LENGTH)) ? CMP_W'(FLOOR_LENGTH)
                                                     : CMP_W'(min_length_r);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_type_r <= FRAME_TYPE_RST;
      min_length_r <= MIN_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FRAME_TYPE: frame_type_r <= cfg_wdata;
        CFG_MIN_LENGTH: min_length_r <= cfg_wdata[5:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    length_nxt     = length_r;
    type_nxt       = type_r;
    crc_nxt        = crc_r;
    rx_crc_nxt     = rx_crc_r;
    payload_nxt    = payload_r;
    ch_idx_nxt     = ch_idx_r;
    status_nxt     = status_r;

    if (cmd.take_byte && byte_count_r < CNT_W'(MAX_PACKET)) begin
      if (pos == CMP_W'(0)) begin
        crc_nxt = '0;
      end else if (pos == CMP_W'(1)) begin
        length_nxt = in_data.data_byte;
      end else begin
        if (pos == CMP_W'(2)) type_nxt = in_data.data_byte;
        if (pos <= len_w) crc_nxt = crc8_upd(crc_r, in_data.data_byte);
        if (pos == len_w + CMP_W'(1)) rx_crc_nxt = in_data.data_byte;
        // payload bytes shift in from the top; byte 3 ends up at bit 0
        if (pos >= CMP_W'(3) && pos < CMP_W'(3 + PAYLOAD_BYTES)) begin
          payload_nxt = {in_data.data_byte, payload_r[PAYLOAD_W-1:8]};
        end
      end
      byte_count_nxt = byte_count_r + CNT_W'(1);
    end

    if (cmd.run_check) begin
      if (cnt_w < minlen_w + CMP_W'(2))          status_nxt = ST_SHORT_PKT;
      else if (len_w < minlen_w)                 status_nxt = ST_SHORT_LEN;
      else if (len_w + CMP_W'(2) > cnt_w)        status_nxt = ST_OVERRUN;
      else if (type_r != frame_type_r)           status_nxt = ST_BAD_TYPE;
      else if (crc_r != rx_crc_r)                status_nxt = ST_BAD_CRC;
      else                                       status_nxt = ST_OK;
      byte_count_nxt = '0;
      crc_nxt        = '0;
      ch_idx_nxt     = '0;
    end

    if (cmd.advance) begin
      payload_nxt = {{CHAN_BITS{1'b0}}, payload_r[PAYLOAD_W-1:CHAN_BITS]};
      ch_idx_nxt  = ch_idx_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      length_r     <= '0;
      type_r       <= '0;
      crc_r        <= '0;
      rx_crc_r     <= '0;
      ch_idx_r     <= '0;
      status_r     <= ST_OK;
    end else begin
      byte_count_r <= byte_count_nxt;
      length_r     <= length_nxt;
      type_r       <= type_nxt;
      crc_r        <= crc_nxt;
      rx_crc_r     <= rx_crc_nxt;
      ch_idx_r     <= ch_idx_nxt;
      status_r     <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
  end

  assign is_ok     = (status_r == ST_OK);
  assign stat.last = !is_ok || (ch_idx_r == 4'(NUM_CHANNELS - 1));

  assign out_data.status        = status_r;
  assign out_data.channel_index = is_ok ? ch_idx_r : 4'd0;
  assign out_data.channel_value = is_ok ? payload_r[CHAN_BITS-1:0] : 11'd0;
  assign out_data.last          = stat.last;

endmodule

// ===== hw/rtl/rc_channel_frame_parser.sv =====
// Channel   | Direction | Handshake          | Payload
// in_       | in        | in_valid/in_ready  | in_t: data_byte, packet_end
// out_      | out       | out_valid/out_ready| out_t: status, channel_index,
//           |           |                    |   channel_value, last
// cfg_      | in        | cfg_we             | cfg_idx, cfg_wdata
//
// Bytes are taken while the sequencer receives. A byte with end mark is
// accepted, then the frame is checked, then one result per cycle while
// out_ready is high: 1 result on error, NUM_CHANNELS on a good frame.
// The single receive/emit sequencer sets this; no byte is taken while
// results drain. Reset (rst_n low, synchronous) returns to receive, with
// all but the payload at reset values. A stalled result holds its transfer.
module rc_channel_frame_parser
  import rcfp_pkg::*;
#(
  parameter int MAX_PACKET   = MAX_PACKET_DEF,
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer: receive bytes, check at end mark, drain results
  rcfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_end    (in_data.packet_end),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // Datapath: byte counter, CRC, header fields, payload shift line
  rcfp_dp #(
    .MAX_PACKET   (MAX_PACKET),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ===== hw/rtl/rcfp_checker.sv =====
`include "rc_channel_frame_parser_defines.svh"

module rcfp_checker
  import rcfp_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  `RCFP_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(in_data))

  `RCFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  `RCFP_ASSERT_IMPL(a_err_single, out_valid && out_data.status != ST_OK,
                    out_data.last && out_data.channel_value == 11'd0)

  `RCFP_ASSERT_IMPL(a_err_index, out_valid && out_data.status != ST_OK,
                    out_data.channel_index == 4'd0)

  `RCFP_ASSERT_NEVER(a_no_overlap, in_ready && out_valid)

endmodule

bind rc_channel_frame_parser rcfp_checker u_rcfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== tb/sv/rc_channel_frame_parser_checker.sv =====
`timescale 1ns / 100ps

module rc_channel_frame_parser_checker
  import rcfp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    mismatches,
  output int                    chans_owed
);

  // shadow registers
  logic [7:0] want_type;
  logic [5:0] want_min;

  // receive state of the packet in flight
  int unsigned rx_count;
  logic [7:0]  len_byte;
  logic [7:0]  type_byte;
  logic [7:0]  crc_acc;
  logic [7:0]  crc_rx;
  logic [7:0]  chan_bytes [PAYLOAD_BYTES];

  out_t chan_expect_q [$];

  function automatic logic [7:0] crc_next(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
    return r;
  endfunction

  // Fold one byte into the packet state; on the end mark, queue the verdict
  // or the decoded channels.
  task automatic take_byte(input in_t item);
    int unsigned          floor_len;
    status_t              verdict;
    logic [PAYLOAD_W-1:0] chan_bits;
    out_t                 res;
    if (rx_count < MAX_PACKET_DEF) begin
      if (rx_count == 0) begin
        crc_acc = 8'h00;
      end else if (rx_count == 1) begin
        len_byte = item.data_byte;
      end else begin
        if (rx_count == 2) type_byte = item.data_byte;
        if (rx_count <= len_byte) crc_acc = crc_next(crc_acc, item.data_byte);
        if (rx_count == int'(len_byte) + 1) crc_rx = item.data_byte;
        if (rx_count >= 3 && rx_count < 3 + PAYLOAD_BYTES)
          chan_bytes[rx_count - 3] = item.data_byte;
      end
      rx_count++;
    end
    if (item.packet_end) begin
      floor_len = (want_min < FLOOR_LENGTH) ? FLOOR_LENGTH : want_min;
      if (rx_count < floor_len + 2)                verdict = ST_SHORT_PKT;
      else if (len_byte < floor_len)               verdict = ST_SHORT_LEN;
      else if (int'(len_byte) + 2 > rx_count)      verdict = ST_OVERRUN;
      else if (type_byte != want_type)             verdict = ST_BAD_TYPE;
      else if (crc_acc != crc_rx)                  verdict = ST_BAD_CRC;
      else                                         verdict = ST_OK;
      rx_count = 0;
      crc_acc  = 8'h00;
      if (verdict != ST_OK) begin
        res = '{verdict, 4'd0, 11'd0, 1'b1};
        chan_expect_q.push_back(res);
      end else begin
        for (int j = 0; j < PAYLOAD_BYTES; j++) chan_bits[8*j +: 8] = chan_bytes[j];
        for (int k = 0; k < NUM_CHANNELS_DEF; k++) begin
          res.status        = ST_OK;
          res.channel_index = 4'(k);
          res.channel_value = chan_bits[k*CHAN_BITS +: CHAN_BITS];
          res.last          = (k == NUM_CHANNELS_DEF - 1);
          chan_expect_q.push_back(res);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      want_type = FRAME_TYPE_RST;
      want_min  = MIN_LENGTH_RST;
      rx_count  = 0;
      len_byte  = 8'h00;
      type_byte = 8'h00;
      crc_acc   = 8'h00;
      crc_rx    = 8'h00;
      chan_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_FRAME_TYPE: want_type = cfg_wdata[7:0];
          CFG_MIN_LENGTH: want_min  = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (chan_expect_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual status=%0d ch=%0d val=0x%0h last=%0b",
                   $time, out_data.status, out_data.channel_index, out_data.channel_value,
                   out_data.last);
        end else begin
          want = chan_expect_q.pop_front();
          if (out_data !== want) begin
            mismatches++;
            $display("%0t: result mismatch: expected status=%0d ch=%0d val=0x%0h last=%0b",
                     $time, want.status, want.channel_index, want.channel_value, want.last);
            $display("%0t:                  actual   status=%0d ch=%0d val=0x%0h last=%0b",
                     $time, out_data.status, out_data.channel_index, out_data.channel_value,
                     out_data.last);
          end
        end
      end
      if (in_valid && in_ready) take_byte(in_data);
    end
    chans_owed = chan_expect_q.size();
  end

endmodule

// ===== tb/sv/tb_rc_channel_frame_parser.sv =====
`timescale 1ns / 100ps

module tb_rc_channel_frame_parser;
  import rcfp_pkg::*;

  // Cycles without any transfer before the run is declared hung. The worst
  // correct gap is an input burst plus the check cycle plus an output stall.
  localparam int STALL_LIMIT   = 2000;
  // Quiet cycles after the last result before a register write or the verdict.
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {
    PK_GOOD,
    PK_SHORT_PKT,
    PK_SHORT_LEN,
    PK_OVERRUN,
    PK_BAD_TYPE,
    PK_BAD_CRC,
    PK_LONG
  } pkt_kind_t;

  typedef enum int {
    PAT_RANDOM,
    PAT_MAX,
    PAT_ZERO,
    PAT_CHECKER
  } chan_pat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int mismatches;
  int chans_owed;

  // Percent chance per transfer of an idle burst on either side; 0 = none.
  int idle_pct;
  int bytes_sent;
  int quiet_cycles;

  // Settings the stimulus builds frames against.
  logic [7:0] cur_type;
  int         cur_min;

  logic [7:0] pkt_bytes [$];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  rc_channel_frame_parser u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  rc_channel_frame_parser_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .chans_owed (chans_owed)
  );

  // Offer one byte; optionally drop valid for a burst first, then hold the
  // byte until the transfer edge.
  task automatic push_byte(input logic [7:0] b, input logic fin);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, packet_end: fin};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // Lay out one packet: sync, length field, type, the channel bytes, filler
  // up to the length field, then the CRC (xor flip). Cut or pad to total_len
  // and send it with the end mark on the final byte.
  task automatic send_frame(input int len_fld, input logic [7:0] ftype,
                            input logic [7:0] flip, input int total_len,
                            input chan_pat_t pat);
    logic [PAYLOAD_W-1:0] chans;
    logic [7:0]           crc;
    chans = '0;
    for (int k = 0; k < NUM_CHANNELS_DEF; k++) begin
      case (pat)
        PAT_MAX:     chans[k*CHAN_BITS +: CHAN_BITS] = 11'h7FF;
        PAT_ZERO:    chans[k*CHAN_BITS +: CHAN_BITS] = 11'h000;
        PAT_CHECKER: chans[k*CHAN_BITS +: CHAN_BITS] = k[0] ? 11'h2AA : 11'h555;
        default: begin
          if ($urandom_range(0, 7) == 0)
            chans[k*CHAN_BITS +: CHAN_BITS] = $urandom_range(0, 1) ? 11'h7FF : 11'h000;
          else
            chans[k*CHAN_BITS +: CHAN_BITS] = 11'($urandom);
        end
      endcase
    end
    pkt_bytes.delete();
    pkt_bytes.push_back(8'($urandom));
    pkt_bytes.push_back(8'(len_fld));
    pkt_bytes.push_back(ftype);
    for (int j = 0; j < PAYLOAD_BYTES; j++) pkt_bytes.push_back(chans[8*j +: 8]);
    while (pkt_bytes.size() <= len_fld) pkt_bytes.push_back(8'($urandom));
    // CRC byte only where it lands past the channel bytes
    if (len_fld >= PAYLOAD_BYTES + 2) begin
      crc = 8'h00;
      for (int i = 2; i <= len_fld; i++) crc = crc8_upd(crc, pkt_bytes[i]);
      pkt_bytes.push_back(crc ^ flip);
    end
    while (pkt_bytes.size() > total_len) void'(pkt_bytes.pop_back());
    while (pkt_bytes.size() < total_len) pkt_bytes.push_back(8'($urandom));
    foreach (pkt_bytes[i]) push_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  // Mostly well-formed frames with random content; the rest break one check or run past MAX_PACKET.
  task automatic send_random_packet();
    int unsigned r;
    pkt_kind_t   kind;
    chan_pat_t   pat;
    int          len_fld;
    int          len_hi;
    int          total;
    logic [7:0]  ftype;
    logic [7:0]  flip;
    r       = $urandom_range(0, 14);
    kind    = (r < 9) ? PK_GOOD : pkt_kind_t'(r - 8);
    pat     = ($urandom_range(0, 5) == 0) ? chan_pat_t'($urandom_range(1, 3)) : PAT_RANDOM;
    len_hi  = (cur_min > 62) ? cur_min : 62;
    len_fld = ($urandom_range(0, 3) == 0) ? $urandom_range(cur_min, len_hi) : cur_min;
    total   = len_fld + 2;
    ftype   = cur_type;
    flip    = 8'h00;
    case (kind)
      PK_GOOD:      if ($urandom_range(0, 3) == 0) total += $urandom_range(1, 3);
      PK_SHORT_PKT: begin
        total   = $urandom_range(1, cur_min + 1);
        len_fld = $urandom_range(0, 255);
      end
      PK_SHORT_LEN: begin
        len_fld = $urandom_range(0, cur_min - 1);
        total   = $urandom_range(cur_min + 2, 64);
      end
      PK_OVERRUN: begin
        len_fld = $urandom_range(cur_min + 1, 255);
        total   = $urandom_range(cur_min + 2, (len_fld < 65) ? len_fld + 1 : 66);
      end
      PK_BAD_TYPE:  ftype = cur_type ^ 8'($urandom_range(1, 255));
      PK_BAD_CRC:   flip = 8'($urandom_range(1, 255));
      PK_LONG:      total = $urandom_range(65, 72);
      default: ;
    endcase
    send_frame(len_fld, ftype, flip, total, pat);
  endtask

  // Drop valid, wait out every owed result, then leave the block quiet so it
  // returns to receive.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (chans_owed != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; only called while the block is idle.
  task automatic set_config(input logic [7:0] ft, input logic [7:0] ml_raw);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_FRAME_TYPE;
    cfg_wdata <= ft;
    @(posedge clk);
    cfg_idx   <= CFG_MIN_LENGTH;
    cfg_wdata <= ml_raw;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_type = ft;
    cur_min  = (ml_raw[5:0] < FLOOR_LENGTH) ? FLOOR_LENGTH : int'(ml_raw[5:0]);
  endtask

  // Result side: random stall bursts, steady ready when idle_pct is zero.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: any transfer or register write restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[rc_channel_frame_parser] ERROR");
      $finish;
    end
  end

  initial begin
    int         ph_start;
    logic [7:0] ft;
    logic [7:0] ml_raw;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_FRAME_TYPE;
    cfg_wdata  <= '0;
    idle_pct   = 20;
    bytes_sent = 0;
    cur_type   = FRAME_TYPE_RST;
    cur_min    = MIN_LENGTH_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Registers at their reset values.
    send_frame(24, cur_type, 8'h00, 26, PAT_MAX);      // shortest good frame, channels at max
    send_frame(24, cur_type, 8'h00, 1, PAT_RANDOM);    // end mark on the sync byte
    send_frame(24, cur_type, 8'h80, 26, PAT_RANDOM);   // corrupted CRC
    settle();

    // A minimum below the floor still demands the full channel payload.
    idle_pct = 30;
    set_config(8'hFF, 8'h00);
    send_frame(24, cur_type, 8'h00, 26, PAT_CHECKER);
    settle();

    // Random phases; the last runs without any idling.
    for (int ph = 0; ph < 2; ph++) begin
      ft     = 8'($urandom);
      ml_raw = (ph == 0) ? 8'($urandom_range(0, 23)) : 8'($urandom_range(24, 34));
      ml_raw[7:6] = 2'($urandom);
      set_config(ft, ml_raw);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 30;
      endcase
      if (ph == 1) idle_pct = 0;
      ph_start = bytes_sent;
      while (bytes_sent - ph_start < 20) send_random_packet();
      settle();
    end

    if (mismatches == 0 && chans_owed == 0)
      $display("[rc_channel_frame_parser] OK");
    else
      $display("[rc_channel_frame_parser] ERROR");
    $finish;
  end

endmodule
